// ===== hw/rtl/liarc_pkg.sv =====
// Shared types and codes for the log index block.
`default_nettype none
package liarc_pkg;
   typedef enum logic [2:0] {
      OP_APPEND  = 3'd0,
      OP_READ    = 3'd1,
      OP_COMPACT = 3'd2,
      OP_NOP     = 3'd3,
      OP_RELEASE = 3'd4
   } opcode_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_APP_SCAN,
      ST_APP_DONE,
      ST_RD_SCAN,
      ST_RD_SLOT,
      ST_RD_PICK,
      ST_RD_EMIT,
      ST_RD_DONE,
      ST_CP_ANCHOR,
      ST_CP_COUNT,
      ST_CP_RETIRE,
      ST_CP_TOMB,
      ST_CP_DONE,
      ST_SIMPLE
   } state_type;

   // which completion drives the result fields
   typedef enum logic [1:0] {
      SEL_SIMPLE  = 2'd0,
      SEL_APPEND  = 2'd1,
      SEL_READ    = 2'd2,
      SEL_COMPACT = 2'd3
   } rsp_sel_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load_req;     // capture request
      logic clr_scan;     // zero scan index and accumulators
      logic step_scan;    // scan one table entry
      logic app_write;    // write appended entry / free slot
      logic rd_claim;     // claim result slot
      logic rd_pick_init; // start min-search pass
      logic rd_emit;      // emit chosen entry, mark emitted
      logic cp_set_anchor;
      logic cp_retire;    // retire scanned entry if superseded
      logic cp_tomb;      // retire best if tombstone
      logic rel_apply;
   } cmd_type;

   // status back to controller
   typedef struct packed {
      logic scan_end;     // current index is last entry
      logic found;        // scan located an entry
      logic more;         // read: unemitted matches remain
      logic fits;         // read: chosen entry fits slot
      logic slot_ok;      // read: free slot exists
      logic multi;        // compaction: more than one match
   } stat_type;
endpackage
`default_nettype wire

// ===== hw/rtl/log_index_append_read_compact.sv =====
// Top level of the write-ahead-log index block.
// Usage: drive req_* and raise start while busy is low; the request is taken
// on that edge and busy rises for the duration of the work. Results appear on
// rsp_* for exactly one cycle each, marked by rsp_strobe; rsp_last flags the
// final result of a request. The receiver cannot stall, so results are never
// held. Append scans the table for the first empty entry, one entry a cycle.
// Read makes a match pass and a slot check, then one minimum-search pass per
// copy descriptor plus a final one; a read with no match or no free slot
// ends after the slot check. Compaction makes up to three table passes, and
// no-op and release make none. All passes walk the single scan index of the
// datapath.
// Reset (synchronous) empties the table, frees every slot, sets the next
// sequence to one and the compaction cursor to zero; the block accepts
// requests right after it.
`default_nettype none
module log_index_append_read_compact #(
   parameter int ENTRIES = 32,
   parameter int SLOTS = 32,
   parameter int SLOT_BYTES = 1024,
   parameter int HEADER_BYTES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [31:0] req_key_hash,
   input  wire logic [4:0]  req_buffer_slot,
   input  wire logic [10:0] req_record_length,
   input  wire logic        req_is_delete,
   output logic             rsp_strobe,
   output logic             rsp_kind,
   output logic             rsp_status,
   output logic [31:0]      rsp_sequence_res,
   output logic [4:0]       rsp_slot_out,
   output logic [10:0]      rsp_byte_offset,
   output logic [10:0]      rsp_byte_count,
   output logic [5:0]       rsp_entry_count,
   output logic             rsp_last
);
   import liarc_pkg::*;
   cmd_type cmd;
   stat_type stat;
   state_type state;
   logic err_short;
   logic [1:0] sel;

   liarc_ctrl u_ctrl (
      .clock, .reset, .start, .req_opcode, .stat, .cmd, .state, .busy,
      .rsp_strobe, .rsp_kind, .rsp_last, .rsp_err_short(err_short), .rsp_sel(sel)
   );

   liarc_dpath #(
      .ENTRIES(ENTRIES), .SLOTS(SLOTS), .SLOT_BYTES(SLOT_BYTES),
      .HEADER_BYTES(HEADER_BYTES)
   ) u_dpath (
      .clock, .reset, .req_opcode, .req_key_hash, .req_buffer_slot,
      .req_record_length, .req_is_delete, .cmd, .state,
      .rsp_kind_c(rsp_kind), .rsp_sel(sel), .stat,
      .out_status(rsp_status), .out_seq(rsp_sequence_res), .out_slot(rsp_slot_out),
      .out_off(rsp_byte_offset), .out_cnt(rsp_byte_count), .out_ec(rsp_entry_count)
   );

   logic unused_top;
   assign unused_top = err_short;

   a_copy_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_kind |-> !rsp_last)
      else $error("copy descriptor marked last");
   a_busy_on_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request taken but block not busy");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !busy)
      else $error("still busy after final result");
endmodule
`default_nettype wire

// ===== hw/rtl/liarc_ctrl.sv =====
// Controller state machine for the log index block.
`default_nettype none
module liarc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [2:0]          req_opcode,
   input  wire liarc_pkg::stat_type stat,
   output liarc_pkg::cmd_type       cmd,
   output liarc_pkg::state_type     state,
   output logic                     busy,
   output logic                     rsp_strobe,
   output logic                     rsp_kind,
   output logic                     rsp_last,
   output logic                     rsp_err_short,
   output logic [1:0]               rsp_sel
);
   import liarc_pkg::*;
   state_type state_ff, state_in;
   assign state = state_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = (state_ff != ST_IDLE);
      rsp_strobe = 1'b0;
      rsp_kind = 1'b0;
      rsp_last = 1'b1;
      rsp_err_short = 1'b0;
      rsp_sel = SEL_SIMPLE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               cmd.clr_scan = 1'b1;
               case (req_opcode)
                  OP_APPEND:  state_in = ST_APP_SCAN;
                  OP_READ:    state_in = ST_RD_SCAN;
                  OP_COMPACT: state_in = ST_CP_ANCHOR;
                  default:    state_in = ST_SIMPLE;
               endcase
            end
         end
         ST_APP_SCAN: begin
            // hold the index on the empty entry so the write lands there
            if (stat.found || stat.scan_end) state_in = ST_APP_DONE;
            else cmd.step_scan = 1'b1;
         end
         ST_APP_DONE: begin
            cmd.app_write = 1'b1;
            rsp_strobe = 1'b1;
            rsp_sel = SEL_APPEND;
            state_in = ST_IDLE;
         end
         ST_RD_SCAN: begin
            cmd.step_scan = 1'b1;
            if (stat.scan_end) state_in = ST_RD_SLOT;
         end
         ST_RD_SLOT: begin
            if (!stat.more || !stat.slot_ok) begin
               rsp_strobe = 1'b1;
               rsp_sel = SEL_READ;
               state_in = ST_IDLE;
            end else begin
               cmd.rd_claim = 1'b1;
               cmd.rd_pick_init = 1'b1;
               state_in = ST_RD_PICK;
            end
         end
         ST_RD_PICK: begin
            cmd.step_scan = 1'b1;
            if (stat.scan_end) state_in = ST_RD_EMIT;
         end
         ST_RD_EMIT: begin
            if (stat.more && stat.fits) begin
               cmd.rd_emit = 1'b1;
               cmd.rd_pick_init = 1'b1;
               rsp_strobe = 1'b1;
               rsp_kind = 1'b1;
               rsp_last = 1'b0;
               state_in = ST_RD_PICK;
            end else begin
               state_in = ST_RD_DONE;
            end
         end
         ST_RD_DONE: begin
            rsp_strobe = 1'b1;
            rsp_sel = SEL_READ;
            state_in = ST_IDLE;
         end
         ST_CP_ANCHOR: begin
            cmd.step_scan = 1'b1;
            if (stat.found) begin
               cmd.cp_set_anchor = 1'b1;
               state_in = ST_CP_COUNT;
            end else if (stat.scan_end) begin
               state_in = ST_CP_DONE;
            end
         end
         ST_CP_COUNT: begin
            cmd.step_scan = 1'b1;
            if (stat.scan_end) state_in = ST_CP_RETIRE;
         end
         ST_CP_RETIRE: begin
            if (!stat.multi) begin
               state_in = ST_CP_DONE;
            end else begin
               cmd.step_scan = 1'b1;
               cmd.cp_retire = 1'b1;
               if (stat.scan_end) state_in = ST_CP_TOMB;
            end
         end
         ST_CP_TOMB: begin
            cmd.cp_tomb = 1'b1;
            state_in = ST_CP_DONE;
         end
         ST_CP_DONE: begin
            rsp_strobe = 1'b1;
            rsp_sel = SEL_COMPACT;
            state_in = ST_IDLE;
         end
         ST_SIMPLE: begin
            cmd.rel_apply = 1'b1;
            rsp_strobe = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== hw/rtl/liarc_dpath.sv =====
// Datapath for the log index block: entry table, slot flags, scan logic.
`default_nettype none
module liarc_dpath #(
   parameter int ENTRIES = 32,
   parameter int SLOTS = 32,
   parameter int SLOT_BYTES = 1024,
   parameter int HEADER_BYTES = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [2:0]           req_opcode,
   input  wire logic [31:0]          req_key_hash,
   input  wire logic [4:0]           req_buffer_slot,
   input  wire logic [10:0]          req_record_length,
   input  wire logic                 req_is_delete,
   input  wire liarc_pkg::cmd_type   cmd,
   input  wire liarc_pkg::state_type state,
   input  wire logic                 rsp_kind_c,
   input  wire logic [1:0]           rsp_sel,
   output liarc_pkg::stat_type       stat,
   output logic                      out_status,
   output logic [31:0]               out_seq,
   output logic [4:0]                out_slot,
   output logic [10:0]               out_off,
   output logic [10:0]               out_cnt,
   output logic [5:0]                out_ec
);
   import liarc_pkg::*;
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW = $clog2(SLOT_BYTES + 2048);

   logic [31:0] seq_ff [ENTRIES];
   logic [31:0] key_ff [ENTRIES];
   logic [4:0]  eslot_ff [ENTRIES];
   logic [10:0] len_ff [ENTRIES];
   logic [ENTRIES-1:0] tomb_ff, comp_ff, match_ff, done_ff;
   logic [SLOTS-1:0] free_ff;
   logic [31:0] nseq_ff;
   logic [IW-1:0] cur_ff, idx_ff, anchor_ff, best_ff, pick_ff;
   logic pick_ok_ff, found_ff, short_ff;
   logic [2:0] op_ff;
   logic [31:0] rkey_ff, bestseq_ff, aseq_ff;
   logic [4:0] rslot_ff;
   logic [10:0] rlen_ff;
   logic rdel_ff;
   logic [5:0] count_ff, got_ff;
   logic [PW-1:0] pos_ff;
   logic [SW-1:0] rs_ff;
   logic rs_err_ff;

   // current scan entry (cursor-relative for compaction anchor)
   logic [IW:0] csum;
   logic [IW-1:0] ci;
   logic live_c, hit_c, scan_end;
   always_comb begin
      csum = {1'b0, cur_ff} + {1'b0, idx_ff};
      if (csum >= (IW+1)'(ENTRIES)) csum = csum - (IW+1)'(ENTRIES);
      ci = (state == ST_CP_ANCHOR) ? csum[IW-1:0] : idx_ff;
      live_c = (seq_ff[ci] != 32'd0) && !comp_ff[ci];
      hit_c = live_c && (key_ff[ci] == rkey_ff);
      scan_end = (idx_ff == IW'(ENTRIES - 1));
   end

   logic [SW:0] fs;
   logic [PW-1:0] newpos;
   always_comb begin
      fs = (SW+1)'(SLOTS);
      for (int s = SLOTS - 1; s >= 0; s--) if (free_ff[s]) fs = (SW+1)'(s);
      newpos = pos_ff + PW'(len_ff[pick_ff]);
   end

   always_comb begin
      stat.scan_end = scan_end;
      stat.found = (state == ST_APP_SCAN) ? (seq_ff[idx_ff] == 32'd0) : live_c;
      stat.more = (state == ST_RD_SLOT) ? (count_ff != 6'd0) : pick_ok_ff;
      stat.fits = (newpos <= PW'(SLOT_BYTES));
      stat.slot_ok = (fs < (SW+1)'(SLOTS));
      stat.multi = (count_ff > 6'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) seq_ff[i] <= '0;
         tomb_ff <= '0;
         comp_ff <= '0;
         free_ff <= '1;
         nseq_ff <= 32'd1;
         cur_ff <= '0;
      end else begin
         if (cmd.load_req) begin
            op_ff <= req_opcode;
            rkey_ff <= req_key_hash;
            rslot_ff <= req_buffer_slot;
            rlen_ff <= req_record_length;
            rdel_ff <= req_is_delete;
            short_ff <= (req_record_length < 11'(HEADER_BYTES));
         end
         if (cmd.clr_scan) begin
            idx_ff <= '0;
            found_ff <= 1'b0;
            count_ff <= '0;
            got_ff <= '0;
            bestseq_ff <= '0;
            best_ff <= '0;
            pos_ff <= '0;
            match_ff <= '0;
            done_ff <= '0;
            rs_err_ff <= 1'b0;
         end
         if (cmd.step_scan) idx_ff <= scan_end ? '0 : idx_ff + 1'b1;
         // append scan: stop at first empty
         if (state == ST_APP_SCAN && seq_ff[idx_ff] == 32'd0) found_ff <= 1'b1;
         if (state == ST_APP_SCAN && short_ff) found_ff <= 1'b0;
         if (cmd.app_write && !short_ff) begin
            aseq_ff <= nseq_ff;
            nseq_ff <= (nseq_ff == 32'hFFFF_FFFF) ? 32'd1 : nseq_ff + 1'b1;
            if (found_ff) begin
               seq_ff[idx_ff] <= nseq_ff;
               key_ff[idx_ff] <= rkey_ff;
               eslot_ff[idx_ff] <= rslot_ff;
               len_ff[idx_ff] <= rlen_ff;
               tomb_ff[idx_ff] <= rdel_ff;
               comp_ff[idx_ff] <= 1'b0;
            end else if (32'(rslot_ff) < 32'(SLOTS)) begin
               free_ff[SW'(rslot_ff)] <= 1'b1;
            end
         end
         // read match scan; also track highest sequence
         if (state == ST_RD_SCAN && hit_c) begin
            match_ff[idx_ff] <= 1'b1;
            count_ff <= count_ff + 1'b1;
            if (seq_ff[idx_ff] >= bestseq_ff) bestseq_ff <= seq_ff[idx_ff];
         end
         if (state == ST_RD_SLOT && count_ff != 6'd0) begin
            if (stat.slot_ok) rs_ff <= fs[SW-1:0];
            else rs_err_ff <= 1'b1;
         end
         if (cmd.rd_claim) free_ff[fs[SW-1:0]] <= 1'b0;
         if (cmd.rd_pick_init) pick_ok_ff <= 1'b0;
         // min-search: lowest sequence, ties by lowest index
         if (state == ST_RD_PICK && match_ff[idx_ff] && !done_ff[idx_ff]) begin
            if (!pick_ok_ff || seq_ff[idx_ff] < seq_ff[pick_ff]) begin
               pick_ok_ff <= 1'b1;
               pick_ff <= idx_ff;
            end
         end
         if (cmd.rd_emit) begin
            done_ff[pick_ff] <= 1'b1;
            pos_ff <= newpos;
         end
         // compaction
         if (cmd.cp_set_anchor) begin
            anchor_ff <= ci;
            rkey_ff <= key_ff[ci];
            cur_ff <= (ci == IW'(ENTRIES - 1)) ? '0 : ci + 1'b1;
            idx_ff <= '0;
         end
         if (state == ST_CP_ANCHOR && !live_c && scan_end) cur_ff <= '0;
         if (state == ST_CP_COUNT && hit_c) begin
            count_ff <= count_ff + 1'b1;
            if (seq_ff[idx_ff] > bestseq_ff) begin
               bestseq_ff <= seq_ff[idx_ff];
               best_ff <= idx_ff;
            end
         end
         if (cmd.cp_retire && hit_c && idx_ff != best_ff) begin
            if (32'(eslot_ff[idx_ff]) < 32'(SLOTS)) free_ff[SW'(eslot_ff[idx_ff])] <= 1'b1;
            comp_ff[idx_ff] <= 1'b1;
            tomb_ff[idx_ff] <= 1'b0;
            seq_ff[idx_ff] <= '0;
            got_ff <= got_ff + 1'b1;
         end
         if (cmd.cp_tomb && tomb_ff[best_ff]) begin
            if (32'(eslot_ff[best_ff]) < 32'(SLOTS)) free_ff[SW'(eslot_ff[best_ff])] <= 1'b1;
            comp_ff[best_ff] <= 1'b1;
            tomb_ff[best_ff] <= 1'b0;
            seq_ff[best_ff] <= '0;
            got_ff <= got_ff + 1'b1;
         end
         if (cmd.rel_apply && op_ff == OP_RELEASE && 32'(rslot_ff) < 32'(SLOTS))
            free_ff[SW'(rslot_ff)] <= 1'b1;
      end
   end

   // result fields
   logic rd_err;
   always_comb begin
      rd_err = (count_ff != 6'd0) && !stat.slot_ok;
      out_status = 1'b0;
      out_seq = '0;
      out_slot = '0;
      out_off = '0;
      out_cnt = '0;
      out_ec = '0;
      if (rsp_kind_c) begin
         out_seq = seq_ff[pick_ff];
         out_slot = eslot_ff[pick_ff];
         out_off = pos_ff[10:0];
         out_cnt = len_ff[pick_ff];
      end else begin
         case (rsp_sel)
            SEL_APPEND: begin
               out_status = short_ff;
               out_seq = short_ff ? 32'd0 : nseq_ff;
            end
            SEL_READ: begin
               if (state == ST_RD_SLOT) begin
                  out_status = rd_err;
               end else begin
                  out_seq = bestseq_ff;
                  out_slot = 5'(rs_ff);
                  out_cnt = pos_ff[10:0];
                  out_ec = count_ff;
               end
            end
            SEL_COMPACT: out_ec = got_ff;
            default: out_status = (op_ff == OP_RELEASE) && (32'(rslot_ff) >= 32'(SLOTS));
         endcase
      end
   end
   logic unused;
   assign unused = ^{aseq_ff, anchor_ff, found_ff, rs_err_ff};
endmodule
`default_nettype wire

// ===== test/log_index_append_read_compact_tb.sv =====
// Self-checking testbench for the write-ahead-log index block.
`timescale 1ns / 1ps
`default_nettype none
module log_index_append_read_compact_tb;
   import liarc_pkg::*;

   localparam int ENTRIES = 32;
   localparam int SLOTS = 32;
   localparam int SLOT_BYTES = 1024;
   localparam int HEADER_BYTES = 8;
   localparam int QUIET_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 180;
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam logic KIND_DONE = 1'b0;
   localparam logic KIND_COPY = 1'b1;
   localparam logic STAT_OK = 1'b0;
   localparam logic STAT_ERR = 1'b1;
   localparam logic [1:0] MARK_TOMB = 2'b01;
   localparam logic [1:0] MARK_GONE = 2'b10;

   typedef struct packed {
      logic        kind;
      logic        status;
      logic [31:0] seq;
      logic [4:0]  slot;
      logic [10:0] off;
      logic [10:0] cnt;
      logic [5:0]  ec;
      logic        last;
   } rsp_t;

   typedef struct {
      logic [2:0]  op;
      logic [31:0] key;
      logic [4:0]  slot;
      logic [10:0] len;
      logic        del;
      bit          typed;
      rsp_t        want;
   } row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_opcode = '0;
   logic [31:0] req_key_hash = '0;
   logic [4:0]  req_buffer_slot = '0;
   logic [10:0] req_record_length = '0;
   logic        req_is_delete = 1'b0;
   logic        rsp_strobe, rsp_kind, rsp_status, rsp_last;
   logic [31:0] rsp_sequence_res;
   logic [4:0]  rsp_slot_out;
   logic [10:0] rsp_byte_offset, rsp_byte_count;
   logic [5:0]  rsp_entry_count;

   log_index_append_read_compact uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_key_hash(req_key_hash),
      .req_buffer_slot(req_buffer_slot), .req_record_length(req_record_length),
      .req_is_delete(req_is_delete),
      .rsp_strobe(rsp_strobe), .rsp_kind(rsp_kind), .rsp_status(rsp_status),
      .rsp_sequence_res(rsp_sequence_res), .rsp_slot_out(rsp_slot_out),
      .rsp_byte_offset(rsp_byte_offset), .rsp_byte_count(rsp_byte_count),
      .rsp_entry_count(rsp_entry_count), .rsp_last(rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mirror of the index state
   logic [31:0] ix_seq [ENTRIES];
   logic [31:0] ix_key [ENTRIES];
   logic [4:0]  ix_slot [ENTRIES];
   logic [10:0] ix_len [ENTRIES];
   logic [1:0]  ix_marks [ENTRIES];
   logic        slot_avail [SLOTS];
   logic [31:0] seq_next;
   int          cursor;

   rsp_t pending_rsp [$];
   row_t sent_rows [$];
   int   errors = 0;
   int   quiet = 0;
   int   burst_left = 0;

   function automatic rsp_t mk(logic kind, logic status, logic [31:0] seq,
                               logic [4:0] slot, logic [10:0] off,
                               logic [10:0] cnt, logic [5:0] ec, logic last);
      rsp_t r;
      r = '{kind, status, seq, slot, off, cnt, ec, last};
      return r;
   endfunction

   function automatic bit live(int i);
      return ix_seq[i] != 0 && ix_marks[i][1] == 1'b0;
   endfunction

   function automatic void retire(int i);
      slot_avail[ix_slot[i]] = 1'b1;
      ix_marks[i] = MARK_GONE;
      ix_seq[i] = '0;
   endfunction

   function automatic void index_reset();
      for (int i = 0; i < ENTRIES; i++) begin
         ix_seq[i] = '0; ix_key[i] = '0; ix_slot[i] = '0;
         ix_len[i] = '0; ix_marks[i] = '0;
      end
      for (int s = 0; s < SLOTS; s++) slot_avail[s] = 1'b1;
      seq_next = 32'd1;
      cursor = 0;
   endfunction

   function automatic logic [5:0] compact_one();
      int anchor, best, count, got;
      logic [31:0] key, bestseq;
      anchor = -1; best = 0; count = 0; got = 0; bestseq = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         int e;
         e = (cursor + i) % ENTRIES;
         if (live(e)) begin
            anchor = e;
            cursor = (e + 1) % ENTRIES;
            break;
         end
      end
      if (anchor < 0) begin
         cursor = 0;
         return '0;
      end
      key = ix_key[anchor];
      for (int i = 0; i < ENTRIES; i++)
         if (live(i) && ix_key[i] == key) begin
            count++;
            if (ix_seq[i] > bestseq) begin
               bestseq = ix_seq[i];
               best = i;
            end
         end
      if (count <= 1) return '0;
      for (int i = 0; i < ENTRIES; i++)
         if (i != best && live(i) && ix_key[i] == key) begin
            retire(i);
            got++;
         end
      if (ix_marks[best][0]) begin
         retire(best);
         got++;
      end
      return got[5:0];
   endfunction

   // works out every result of one request and updates the mirror
   function automatic void predict_request(row_t r);
      int          hits [$];
      int          rslot, n, k, x;
      logic [31:0] pos, s;
      case (r.op)
         OP_APPEND: begin
            if (r.len < HEADER_BYTES) begin
               pending_rsp.push_back(mk(KIND_DONE, STAT_ERR, 0, 0, 0, 0, 0, 1'b1));
               return;
            end
            k = -1;
            for (int i = 0; i < ENTRIES; i++)
               if (ix_seq[i] == 0) begin
                  k = i;
                  break;
               end
            s = seq_next;
            seq_next = seq_next + 1;
            if (seq_next == 0) seq_next = 32'd1;
            if (k < 0) slot_avail[r.slot] = 1'b1;
            else begin
               ix_seq[k] = s; ix_key[k] = r.key; ix_slot[k] = r.slot;
               ix_len[k] = r.len; ix_marks[k] = r.del ? MARK_TOMB : 2'b00;
            end
            pending_rsp.push_back(mk(KIND_DONE, STAT_OK, s, 0, 0, 0, 0, 1'b1));
         end
         OP_READ: begin
            for (int i = 0; i < ENTRIES; i++)
               if (live(i) && ix_key[i] == r.key) hits.push_back(i);
            n = hits.size();
            if (n == 0) begin
               pending_rsp.push_back(mk(KIND_DONE, STAT_OK, 0, 0, 0, 0, 0, 1'b1));
               return;
            end
            // stable ordering by sequence, ties by table index
            for (int i = 1; i < n; i++) begin
               int j;
               x = hits[i];
               j = i;
               while (j > 0 && ix_seq[hits[j-1]] > ix_seq[x]) begin
                  hits[j] = hits[j-1];
                  j--;
               end
               hits[j] = x;
            end
            rslot = -1;
            for (int q = 0; q < SLOTS; q++)
               if (slot_avail[q]) begin
                  rslot = q;
                  break;
               end
            if (rslot < 0) begin
               pending_rsp.push_back(mk(KIND_DONE, STAT_ERR, 0, 0, 0, 0, 0, 1'b1));
               return;
            end
            slot_avail[rslot] = 1'b0;
            pos = '0;
            for (int i = 0; i < n; i++) begin
               x = hits[i];
               if (pos + ix_len[x] > SLOT_BYTES) break;
               pending_rsp.push_back(mk(KIND_COPY, STAT_OK, ix_seq[x], ix_slot[x],
                                        pos[10:0], ix_len[x], 0, 1'b0));
               pos = pos + ix_len[x];
            end
            pending_rsp.push_back(mk(KIND_DONE, STAT_OK, ix_seq[hits[n-1]], rslot[4:0],
                                     0, pos[10:0], n[5:0], 1'b1));
         end
         OP_COMPACT:
            pending_rsp.push_back(mk(KIND_DONE, STAT_OK, 0, 0, 0, 0, compact_one(), 1'b1));
         OP_RELEASE: begin
            slot_avail[r.slot] = 1'b1;
            pending_rsp.push_back(mk(KIND_DONE, STAT_OK, 0, 0, 0, 0, 0, 1'b1));
         end
         default:
            pending_rsp.push_back(mk(KIND_DONE, STAT_OK, 0, 0, 0, 0, 0, 1'b1));
      endcase
   endfunction

   task automatic report(string what, rsp_t got, rsp_t want);
      $display("%0t mismatch %s: got %p want %p", $realtime, what, got, want);
      errors++;
   endtask

   // result check and request capture, both sampled at the edge
   always @(posedge clock) begin
      rsp_t got, want;
      row_t r;
      if (!reset) begin
         if (rsp_strobe) begin
            got = mk(rsp_kind, rsp_status, rsp_sequence_res, rsp_slot_out,
                     rsp_byte_offset, rsp_byte_count, rsp_entry_count, rsp_last);
            if (pending_rsp.size() == 0) report("unexpected result", got, '0);
            else begin
               want = pending_rsp.pop_front();
               if (got !== want) report("result", got, want);
            end
         end
         if (start && !busy) begin
            r = sent_rows.pop_front();
            if (r.typed) begin
               // typed row: the mirror still tracks state, the table value is checked
               predict_request(r);
               void'(pending_rsp.pop_back());
               pending_rsp.push_back(r.want);
            end else
               predict_request(r);
         end
         quiet <= (rsp_strobe || (start && !busy)) ? 0 : quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("log_index_append_read_compact_tb: done, errors");
            $finish;
         end
      end
   end

   // called at a rising edge; returns at the taking edge or after an idle gap
   task automatic send(row_t r);
      sent_rows.push_back(r);
      start <= 1'b1;
      req_opcode <= r.op;
      req_key_hash <= r.key;
      req_buffer_slot <= r.slot;
      req_record_length <= r.len;
      req_is_delete <= r.del;
      do @(negedge clock); while (busy);
      @(posedge clock);
      if (burst_left > 0) burst_left--;
      else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30)
                                                  : $urandom_range(0, 6);
      end
   endtask

   function automatic row_t rq(logic [2:0] op, logic [31:0] key, logic [4:0] slot,
                               logic [10:0] len, logic del);
      row_t r;
      r = '{op, key, slot, len, del, 1'b0, '0};
      return r;
   endfunction

   function automatic row_t rt(row_t r, rsp_t want);
      r.typed = 1'b1;
      r.want = want;
      return r;
   endfunction

   logic [31:0] hot_keys [6] = '{32'h0, 32'hFFFF_FFFF, 32'hA5A5_5A5A,
                                 32'h1234_5678, 32'h8000_0001, 32'h7FFF_FFFE};

   function automatic logic [10:0] pick_len();
      case ($urandom_range(0, 9))
         0: return 11'($urandom_range(0, 2047));
         1: return 11'($urandom_range(0, HEADER_BYTES - 1));
         2: return 11'($urandom_range(300, 1024));
         default: return 11'($urandom_range(HEADER_BYTES, 160));
      endcase
   endfunction

   function automatic row_t pick_append();
      return rq(OP_APPEND, ($urandom_range(0, 7) == 0) ? $urandom : hot_keys[$urandom_range(0, 5)],
                5'($urandom_range(0, 31)), pick_len(), $urandom_range(0, 4) == 0);
   endfunction

   function automatic row_t pick_read();
      return rq(OP_READ, ($urandom_range(0, 9) == 0) ? $urandom : hot_keys[$urandom_range(0, 5)],
                5'($urandom), 11'($urandom), 1'($urandom));
   endfunction

   function automatic row_t pick_any();
      int w;
      w = $urandom_range(0, 99);
      if (w < 40) return pick_append();
      if (w < 65) return pick_read();
      if (w < 78) return rq(OP_COMPACT, $urandom, 5'($urandom), 11'($urandom), 1'($urandom));
      if (w < 92) return rq(OP_RELEASE, $urandom, 5'($urandom), 11'($urandom), 1'($urandom));
      return rq(3'($urandom_range(OP_NOP, OP_SPARE_HI)), $urandom, 5'($urandom),
                11'($urandom), 1'($urandom));
   endfunction

   row_t directed [$];
   rsp_t ok_done, err_done;

   initial begin
      index_reset();
      ok_done = mk(KIND_DONE, STAT_OK, 0, 0, 0, 0, 0, 1'b1);
      err_done = mk(KIND_DONE, STAT_ERR, 0, 0, 0, 0, 0, 1'b1);
      directed = '{
         rt(rq(OP_NOP, '1, '1, '1, 1'b1), ok_done),
         rt(rq(OP_SPARE_LO, 0, 0, 0, 0), ok_done),
         rt(rq(OP_SPARE_MID, 0, 0, 0, 0), ok_done),
         rt(rq(OP_SPARE_HI, '1, '1, '1, 1'b1), ok_done),
         rt(rq(OP_APPEND, 32'h55, 3, HEADER_BYTES - 1, 0), err_done),
         rt(rq(OP_APPEND, 32'h55, 3, 0, 1'b1), err_done),
         rt(rq(OP_READ, 32'h55, 0, 0, 0), ok_done),
         rt(rq(OP_APPEND, 32'h0, 0, HEADER_BYTES, 0),
            mk(KIND_DONE, STAT_OK, 1, 0, 0, 0, 0, 1'b1)),
         rt(rq(OP_APPEND, '1, 31, 11'h7FF, 0),
            mk(KIND_DONE, STAT_OK, 2, 0, 0, 0, 0, 1'b1)),
         rq(OP_READ, 32'h0, 0, 0, 0),
         rq(OP_READ, '1, '1, '1, 1'b1),
         rq(OP_APPEND, 32'h0, 17, SLOT_BYTES, 1'b1),
         rq(OP_APPEND, 32'h0, 9, 20, 0),
         rq(OP_READ, 32'h0, 0, 0, 0),
         rq(OP_COMPACT, 0, 0, 0, 0),
         rq(OP_COMPACT, 0, 0, 0, 0),
         rq(OP_APPEND, '1, 30, 100, 1'b1),
         rq(OP_COMPACT, 0, 0, 0, 0),
         rq(OP_READ, '1, 0, 0, 0),
         rt(rq(OP_RELEASE, 0, 31, 0, 0), ok_done),
         rt(rq(OP_RELEASE, '1, 0, '1, 1'b1), ok_done),
         rq(OP_COMPACT, 0, 0, 0, 0),
         rq(OP_COMPACT, 0, 0, 0, 0)
      };
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send(directed[i]);
      // fill the index past full, then exhaust the result slots
      repeat (36) send(pick_append());
      repeat (34) send(pick_read());
      repeat (RANDOM_ITEMS - 70 - directed.size()) send(pick_any());
      start <= 1'b0;
      @(posedge clock);
      while (busy || pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("log_index_append_read_compact_tb: done, clean");
      else $display("log_index_append_read_compact_tb: done, errors");
      $finish;
   end
endmodule
`default_nettype wire
